// ----- src/wrm_pkg.sv -----
// wrm_pkg: shared constants, payload structs and register indexes for the
// windowed RMS meter. No dependencies; every other file imports it.
`timescale 1ns / 1ps

package wrm_pkg;

   // Window length in sample pairs; must be a power of two (32..256)
   localparam int WINDOW       = 64;
   localparam int WINDOW_LOG2  = $clog2(WINDOW);
   // Bits of each raw sample that take part (8..12)
   localparam int SAMPLE_BITS  = 12;

   localparam int FIELD_W      = 12;
   localparam int DIFF_W       = FIELD_W + 2;
   localparam int SQ_W         = 2 * SAMPLE_BITS;
   localparam int SUM_W        = 32;
   localparam int CNT_W        = $clog2(WINDOW);

   localparam int GAIN_W       = 24;
   localparam int OUT_W        = 24;
   localparam int FRAC_SHIFT   = 16;
   localparam int MEAN_W       = SUM_W - WINDOW_LOG2;
   localparam int RAD_W        = MEAN_W + FRAC_SHIFT;
   localparam int ROOT_W       = (RAD_W + 1) / 2;
   localparam int RAD_PAD_W    = 2 * ROOT_W;
   localparam int REM_W        = ROOT_W + 2;
   localparam int PROD_W       = ROOT_W + GAIN_W;
   localparam int STEP_W       = $clog2(ROOT_W);

   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 24;

   localparam logic [FIELD_W-1:0] BIAS_RESET  = FIELD_W'(2048);
   localparam logic [GAIN_W-1:0]  GAIN_RESET  = GAIN_W'(65536);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DC_BIAS      = 2'd0,
      CSR_CALIB_OFFSET = 2'd1,
      CSR_CURRENT_GAIN = 2'd2,
      CSR_VOLTAGE_GAIN = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [FIELD_W-1:0] current_sample;
      logic [FIELD_W-1:0] voltage_sample;
   } wrm_req_type;

   typedef struct packed {
      logic [OUT_W-1:0] rms_current;
      logic [OUT_W-1:0] rms_voltage;
   } wrm_rsp_type;

   typedef struct packed {
      logic [SUM_W-1:0] current_sum;
      logic [SUM_W-1:0] voltage_sum;
   } wrm_sums_type;

   typedef struct packed {
      logic valid;
      logic full;
   } wrm_queue_status_type;

endpackage

// ----- src/windowed_rms_meter_core.sv -----
// windowed_rms_meter_core: top level of the windowed true-RMS meter.
// Holds the configuration registers; instantiates wrm_front, wrm_queue, wrm_back.
// Depends on wrm_pkg.
//
//   channel | ports                          | moves
//   --------+--------------------------------+--------------------------------
//   request | req_valid / req_ready / req_data | one raw current/voltage pair
//   result  | rsp_valid / rsp_ready / rsp_data | current and voltage RMS, Q16.8
//   config  | csr_write_en / csr_index / csr_wdata | register write, no wait
//
// Sample pairs are taken one per cycle; the front squares in one stage and
// accumulates in the next. A window closes every WINDOW transactions and its
// sums go to a two-entry queue. The back's work per window is set by the shared
// one-digit-per-cycle square root; the queue lets the front keep running
// meanwhile.
// Reset is synchronous and active high; it clears all control state and loads
// the register defaults. The front stalls only when a closing transaction finds
// the queue full; the back holds a finished result while rsp_ready is low.
`timescale 1ns / 1ps

module windowed_rms_meter_core import wrm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  wrm_req_type            req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output wrm_rsp_type            rsp_data,
   input  logic                   csr_write_en,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // configuration registers
   logic [FIELD_W-1:0]        bias_ff,  bias_in;
   logic signed [FIELD_W-1:0] calib_ff, calib_in;
   logic [GAIN_W-1:0]         igain_ff, igain_in;
   logic [GAIN_W-1:0]         vgain_ff, vgain_in;

   // front/back coupling
   wrm_queue_status_type      q_status;
   logic                      q_push;
   logic                      q_pop;
   wrm_sums_type              q_push_data;
   wrm_sums_type              q_pop_data;

   // decode a register write; keep only the register's own low bits
   always_comb begin
      bias_in  = bias_ff;
      calib_in = calib_ff;
      igain_in = igain_ff;
      vgain_in = vgain_ff;
      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_DC_BIAS:      bias_in  = csr_wdata[FIELD_W-1:0];
            CSR_CALIB_OFFSET: calib_in = $signed(csr_wdata[FIELD_W-1:0]);
            CSR_CURRENT_GAIN: igain_in = csr_wdata[GAIN_W-1:0];
            CSR_VOLTAGE_GAIN: vgain_in = csr_wdata[GAIN_W-1:0];
            default: begin
               bias_in = bias_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_ff  <= BIAS_RESET;
         calib_ff <= '0;
         igain_ff <= GAIN_RESET;
         vgain_ff <= GAIN_RESET;
      end else begin
         bias_ff  <= bias_in;
         calib_ff <= calib_in;
         igain_ff <= igain_in;
         vgain_ff <= vgain_in;
      end
   end

   // accept, square and accumulate
   wrm_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .dc_bias      (bias_ff),
      .calib_offset (calib_ff),
      .q_status     (q_status),
      .q_push       (q_push),
      .q_push_data  (q_push_data)
   );

   // decouple window closing from the root computation
   wrm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .status    (q_status),
      .pop_data  (q_pop_data)
   );

   // root, scale, saturate, deliver
   wrm_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_status     (q_status),
      .q_pop_data   (q_pop_data),
      .q_pop        (q_pop),
      .current_gain (igain_ff),
      .voltage_gain (vgain_ff),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

   // a window never lands on a full queue
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_status.full)
      else $error("window sums pushed into a full queue");

   // the back only pops what is there
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_status.valid)
      else $error("queue popped while empty");

   // no result right after reset
   assert property (@(posedge clock) $past(reset) && !reset |-> !rsp_valid)
      else $error("result valid right after reset");

   // the request side stalls only when the queue is full
   assert property (@(posedge clock) disable iff (reset) !req_ready |-> q_status.full)
      else $error("request stalled with room in the queue");

endmodule

// ----- src/wrm_front.sv -----
// wrm_front: accepts sample pairs, centers, clamps and squares them, and
// accumulates the window sums. Pushes finished sums to the queue. Uses wrm_pkg.
`timescale 1ns / 1ps

module wrm_front import wrm_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  wrm_req_type               req_data,
   input  logic [FIELD_W-1:0]        dc_bias,
   input  logic signed [FIELD_W-1:0] calib_offset,
   input  wrm_queue_status_type      q_status,
   output logic                      q_push,
   output wrm_sums_type              q_push_data
);

   localparam logic signed [DIFF_W-1:0] LIMIT_POS = DIFF_W'((1 << SAMPLE_BITS) - 1);
   localparam logic signed [DIFF_W-1:0] LIMIT_NEG = -LIMIT_POS;

   function automatic logic [SQ_W-1:0] centered_square(
      input logic [FIELD_W-1:0]        raw,
      input logic [FIELD_W-1:0]        bias,
      input logic signed [FIELD_W-1:0] calib
   );
      logic signed [DIFF_W-1:0] d;
      logic [SAMPLE_BITS-1:0]   mag;
      d = $signed(DIFF_W'(raw[SAMPLE_BITS-1:0])) - $signed(DIFF_W'(bias))
          - DIFF_W'(calib);
      if (d > LIMIT_POS || d < LIMIT_NEG) begin
         mag = SAMPLE_BITS'(LIMIT_POS);
      end else if (d < 0) begin
         mag = SAMPLE_BITS'(-d);
      end else begin
         mag = SAMPLE_BITS'(d);
      end
      return SQ_W'(mag) * SQ_W'(mag);
   endfunction

   logic              accept;
   logic              advance;
   logic              win_end;

   logic              sq_valid_ff, sq_valid_in;
   logic              sq_last_ff,  sq_last_in;
   logic [SQ_W-1:0]   sq_cur_ff,   sq_cur_in;
   logic [SQ_W-1:0]   sq_vol_ff,   sq_vol_in;
   logic [CNT_W-1:0]  count_ff,    count_in;
   logic [SUM_W-1:0]  sum_cur_ff,  sum_cur_in;
   logic [SUM_W-1:0]  sum_vol_ff,  sum_vol_in;
   logic [SUM_W-1:0]  sum_cur_add, sum_vol_add;

   // hold the closing square while the queue is full
   assign advance   = sq_valid_ff && !(sq_last_ff && q_status.full);
   assign req_ready = !sq_valid_ff || advance;
   assign accept    = req_valid && req_ready;
   assign win_end   = (count_ff == CNT_W'(WINDOW - 1));

   assign sum_cur_add = sum_cur_ff + SUM_W'(sq_cur_ff);
   assign sum_vol_add = sum_vol_ff + SUM_W'(sq_vol_ff);

   assign q_push                  = advance && sq_last_ff;
   assign q_push_data.current_sum = sum_cur_add;
   assign q_push_data.voltage_sum = sum_vol_add;

   always_comb begin
      sq_valid_in = sq_valid_ff;
      sq_last_in  = sq_last_ff;
      sq_cur_in   = sq_cur_ff;
      sq_vol_in   = sq_vol_ff;
      count_in    = count_ff;
      sum_cur_in  = sum_cur_ff;
      sum_vol_in  = sum_vol_ff;
      if (advance) begin
         sq_valid_in = 1'b0;
         if (sq_last_ff) begin
            sum_cur_in = '0;
            sum_vol_in = '0;
         end else begin
            sum_cur_in = sum_cur_add;
            sum_vol_in = sum_vol_add;
         end
      end
      if (accept) begin
         sq_valid_in = 1'b1;
         sq_last_in  = win_end;
         sq_cur_in   = centered_square(req_data.current_sample, dc_bias, calib_offset);
         sq_vol_in   = centered_square(req_data.voltage_sample, dc_bias, calib_offset);
         count_in    = win_end ? '0 : count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
         sq_last_ff  <= 1'b0;
         count_ff    <= '0;
         sum_cur_ff  <= '0;
         sum_vol_ff  <= '0;
      end else begin
         sq_valid_ff <= sq_valid_in;
         sq_last_ff  <= sq_last_in;
         count_ff    <= count_in;
         sum_cur_ff  <= sum_cur_in;
         sum_vol_ff  <= sum_vol_in;
      end
   end

   always_ff @(posedge clock) begin
      sq_cur_ff <= sq_cur_in;
      sq_vol_ff <= sq_vol_in;
   end

endmodule

// ----- src/wrm_queue.sv -----
// wrm_queue: short FIFO of finished window sums between front and back.
// Uses wrm_pkg.
`timescale 1ns / 1ps

module wrm_queue import wrm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  wrm_sums_type         push_data,
   input  logic                 pop,
   output wrm_queue_status_type status,
   output wrm_sums_type         pop_data
);

   wrm_sums_type       entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff,  count_in;

   assign status.valid = (count_ff != '0);
   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_data     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- src/wrm_back.sv -----
// wrm_back: per window, shared digit-by-digit square root, gain multiply,
// saturation and the result register. Uses wrm_pkg.
`timescale 1ns / 1ps

module wrm_back import wrm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  wrm_queue_status_type q_status,
   input  wrm_sums_type         q_pop_data,
   output logic                 q_pop,
   input  logic [GAIN_W-1:0]    current_gain,
   input  logic [GAIN_W-1:0]    voltage_gain,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output wrm_rsp_type          rsp_data
);

   typedef enum logic [4:0] {
      BK_IDLE  = 5'b00001,
      BK_ROOT  = 5'b00010,
      BK_MUL   = 5'b00100,
      BK_SCALE = 5'b01000,
      BK_OUT   = 5'b10000
   } bk_state_type;

   // mean = floor(sum / WINDOW), then 16 zero bits give 8 root fraction bits
   function automatic logic [RAD_PAD_W-1:0] load_radicand(input logic [SUM_W-1:0] sum);
      return RAD_PAD_W'({sum[SUM_W-1:WINDOW_LOG2], {FRAC_SHIFT{1'b0}}});
   endfunction

   bk_state_type          state_ff, state_in;
   logic                  chan_ff,  chan_in;
   logic [STEP_W-1:0]     step_ff,  step_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [SUM_W-1:0]      vsum_ff,  vsum_in;
   logic [RAD_PAD_W-1:0]  rad_ff,   rad_in;
   logic [REM_W-1:0]      rem_ff,   rem_in;
   logic [ROOT_W-1:0]     root_ff,  root_in;
   logic [PROD_W-1:0]     prod_ff,  prod_in;
   logic [OUT_W-1:0]      resc_ff,  resc_in;
   wrm_rsp_type           rsp_ff,   rsp_in;

   logic [REM_W-1:0]      rem_shift;
   logic [REM_W-1:0]      trial;
   logic                  take;
   logic [GAIN_W-1:0]     gain_sel;
   logic [OUT_W-1:0]      scaled;

   assign rem_shift = {rem_ff[REM_W-3:0], rad_ff[RAD_PAD_W-1 -: 2]};
   assign trial     = {root_ff, 2'b01};
   assign take      = (rem_shift >= trial);
   assign gain_sel  = chan_ff ? voltage_gain : current_gain;
   assign scaled    = (|prod_ff[PROD_W-1:FRAC_SHIFT+OUT_W]) ? '1 :
                      prod_ff[FRAC_SHIFT+OUT_W-1:FRAC_SHIFT];

   assign q_pop     = (state_ff == BK_IDLE) && q_status.valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      chan_in      = chan_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      vsum_in      = vsum_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      prod_in      = prod_ff;
      resc_in      = resc_ff;
      rsp_in       = rsp_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_status.valid) begin
               vsum_in  = q_pop_data.voltage_sum;
               rad_in   = load_radicand(q_pop_data.current_sum);
               rem_in   = '0;
               root_in  = '0;
               step_in  = STEP_W'(ROOT_W - 1);
               chan_in  = 1'b0;
               state_in = BK_ROOT;
            end
         end
         BK_ROOT: begin
            rad_in  = {rad_ff[RAD_PAD_W-3:0], 2'b00};
            rem_in  = take ? rem_shift - trial : rem_shift;
            root_in = {root_ff[ROOT_W-2:0], take};
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               state_in = BK_MUL;
            end
         end
         BK_MUL: begin
            prod_in  = PROD_W'(root_ff) * PROD_W'(gain_sel);
            state_in = BK_SCALE;
         end
         BK_SCALE: begin
            if (!chan_ff) begin
               resc_in  = scaled;
               rad_in   = load_radicand(vsum_ff);
               rem_in   = '0;
               root_in  = '0;
               step_in  = STEP_W'(ROOT_W - 1);
               chan_in  = 1'b1;
               state_in = BK_ROOT;
            end else begin
               state_in = BK_OUT;
            end
         end
         BK_OUT: begin
            // wait for the result register to drain; the voltage product holds
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.rms_current = resc_ff;
               rsp_in.rms_voltage = scaled;
               rsp_valid_in       = 1'b1;
               state_in           = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         chan_ff      <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chan_ff      <= chan_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      vsum_ff <= vsum_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      prod_ff <= prod_in;
      resc_ff <= resc_in;
      rsp_ff  <= rsp_in;
   end

endmodule

// ----- test/tb_windowed_rms_meter_core.sv -----
// tb_windowed_rms_meter_core: self-checking testbench for the windowed RMS meter.
// Streams random sample pairs through several register settings and checks
// every window result against a local model. Depends on wrm_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_windowed_rms_meter_core;
   import wrm_pkg::*;

   // Pairs to send before the random part may stop, and windows it must close
   localparam int ITEM_TARGET   = 1600;
   localparam int WINDOW_TARGET = 20;
   // Cycles to let the front pipeline and the root engine drain before a write
   localparam int SETTLE_CYCLES = 120;
   localparam int SAMPLE_MAX    = (1 << FIELD_W) - 1;
   localparam int CLAMP_LIMIT   = (1 << SAMPLE_BITS) - 1;

   // Window model plus the queue of window results still owed by the block
   class rms_scoreboard;
      logic [FIELD_W-1:0]        bias;
      logic signed [FIELD_W-1:0] calib;
      logic [GAIN_W-1:0]         cur_gain;
      logic [GAIN_W-1:0]         volt_gain;
      logic [SUM_W-1:0]          cur_sum;
      logic [SUM_W-1:0]          volt_sum;
      int unsigned               pairs_taken;
      wrm_rsp_type               owed_q[$];
      int                        mismatches;
      int                        windows_closed;

      function new();
         bias           = BIAS_RESET;
         calib          = '0;
         cur_gain       = GAIN_RESET;
         volt_gain      = GAIN_RESET;
         cur_sum        = '0;
         volt_sum       = '0;
         pairs_taken    = 0;
         mismatches     = 0;
         windows_closed = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_DC_BIAS:      bias      = data[FIELD_W-1:0];
            CSR_CALIB_OFFSET: calib     = data[FIELD_W-1:0];
            CSR_CURRENT_GAIN: cur_gain  = data[GAIN_W-1:0];
            CSR_VOLTAGE_GAIN: volt_gain = data[GAIN_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [SUM_W-1:0] centered_sq(logic [FIELD_W-1:0] raw);
         int s;
         int b;
         int c;
         int d;
         s = int'(raw & FIELD_W'(CLAMP_LIMIT));
         b = int'(bias);
         c = calib;
         d = s - b - c;
         if (d > CLAMP_LIMIT) d = CLAMP_LIMIT;
         if (d < -CLAMP_LIMIT) d = -CLAMP_LIMIT;
         return SUM_W'(d * d);
      endfunction

      function logic [63:0] isqrt_floor(logic [63:0] v);
         logic [63:0] root;
         logic [63:0] bitv;
         root = '0;
         bitv = 64'd1 << 46;
         while (bitv > v) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (v >= root + bitv) begin
               v    = v - (root + bitv);
               root = (root >> 1) + bitv;
            end else begin
               root = root >> 1;
            end
            bitv = bitv >> 2;
         end
         return root;
      endfunction

      function logic [OUT_W-1:0] scaled_rms(logic [SUM_W-1:0] sum, logic [GAIN_W-1:0] gain);
         logic [63:0] mean;
         logic [63:0] root;
         logic [63:0] scaled;
         mean   = 64'(sum) / 64'(WINDOW);
         root   = isqrt_floor(mean << 16);
         scaled = (root * 64'(gain)) >> 16;
         if (scaled > 64'(24'hFFFFFF)) scaled = 64'(24'hFFFFFF);
         return scaled[OUT_W-1:0];
      endfunction

      function void note_request(wrm_req_type item);
         wrm_rsp_type owed;
         cur_sum  = cur_sum + centered_sq(item.current_sample);
         volt_sum = volt_sum + centered_sq(item.voltage_sample);
         if (pairs_taken + 1 < WINDOW) begin
            pairs_taken++;
         end else begin
            owed.rms_current = scaled_rms(cur_sum, cur_gain);
            owed.rms_voltage = scaled_rms(volt_sum, volt_gain);
            owed_q.push_back(owed);
            cur_sum     = '0;
            volt_sum    = '0;
            pairs_taken = 0;
            windows_closed++;
         end
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10) $display("mismatch: %s", msg);
      endfunction

      function void check_response(wrm_rsp_type got);
         wrm_rsp_type owed;
         if (owed_q.size() == 0) begin
            flag($sformatf("result %0d/%0d with no window pending",
                           got.rms_current, got.rms_voltage));
            return;
         end
         owed = owed_q.pop_front();
         if (got.rms_current !== owed.rms_current)
            flag($sformatf("rms_current expected %0d got %0d",
                           owed.rms_current, got.rms_current));
         if (got.rms_voltage !== owed.rms_voltage)
            flag($sformatf("rms_voltage expected %0d got %0d",
                           owed.rms_voltage, got.rms_voltage));
      endfunction

      function int pending();
         return owed_q.size();
      endfunction
   endclass

   logic                  clock        = 1'b0;
   logic                  reset        = 1'b1;
   logic                  req_valid    = 1'b0;
   logic                  req_ready;
   wrm_req_type           req_data     = '0;
   logic                  rsp_valid;
   logic                  rsp_ready    = 1'b0;
   wrm_rsp_type           rsp_data;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index    = '0;
   logic [CSR_DATA_W-1:0] csr_wdata    = '0;

   rms_scoreboard sb = new();
   int  sent     = 0;
   bit  req_calm = 1'b0;
   bit  rsp_calm = 1'b0;

   windowed_rms_meter_core dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #1 clock = ~clock;

   // Mostly short gaps, a few long ones; none at all while calm
   function automatic int pick_gap(bit calm);
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   // Draw one sample: full range, hugging the bias point, or a rail
   function automatic logic [FIELD_W-1:0] pick_sample();
      int r;
      int near;
      r = $urandom_range(0, 99);
      if (r < 50) return FIELD_W'($urandom);
      if (r < 80) begin
         near = int'(sb.bias) + int'(sb.calib) + $urandom_range(0, 64) - 32;
         return FIELD_W'(near);
      end
      if (r < 90) return '0;
      return FIELD_W'(SAMPLE_MAX);
   endfunction

   function automatic logic [GAIN_W-1:0] pick_gain();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return GAIN_RESET;
         3: return GAIN_W'($urandom_range(1, 255));
         default: return GAIN_W'($urandom);
      endcase
   endfunction

   // Present one pair and hold it until the core takes it; keep valid high on
   // back-to-back transactions so it never drops and rises in one step
   task automatic send_pair(wrm_req_type item);
      int gap = pick_gap(req_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      sb.note_request(item);
      sent++;
   endtask

   task automatic send_random(int count);
      wrm_req_type item;
      repeat (count) begin
         item.current_sample = pick_sample();
         item.voltage_sample = pick_sample();
         send_pair(item);
      end
   endtask

   // Write all four registers on consecutive edges, starting at a random index
   task automatic write_regs(logic [CSR_DATA_W-1:0] bias_w, logic [CSR_DATA_W-1:0] calib_w,
                             logic [CSR_DATA_W-1:0] cgain_w, logic [CSR_DATA_W-1:0] vgain_w);
      logic [CSR_DATA_W-1:0] vals [4];
      csr_index_type         idx;
      int                    first;
      int                    k;
      vals[CSR_DC_BIAS]      = bias_w;
      vals[CSR_CALIB_OFFSET] = calib_w;
      vals[CSR_CURRENT_GAIN] = cgain_w;
      vals[CSR_VOLTAGE_GAIN] = vgain_w;
      first = $urandom_range(0, 3);
      for (k = 0; k < 4; k++) begin
         idx = csr_index_type'((first + k) % 4);
         csr_write_en <= 1'b1;
         csr_index    <= idx;
         csr_wdata    <= vals[idx];
         @(posedge clock);
         sb.write_reg(idx, vals[idx]);
      end
      csr_write_en <= 1'b0;
   endtask

   // Hold until every owed window has come back, then let the pipeline drain
   task automatic wait_idle();
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Pick the register setting of one phase; the first three are fixed corners
   task automatic program_phase(int phase);
      logic [CSR_DATA_W-1:0] junk;
      junk = CSR_DATA_W'($urandom);
      case (phase)
         // Lowest offsets, top gains: samples clamp high and outputs saturate
         0: write_regs({junk[11:0], 12'd0}, {junk[23:12], 12'h800}, '1, '1);
         // Highest offsets, zero gains: samples clamp low and outputs read zero
         1: write_regs({junk[11:0], 12'hFFF}, {junk[23:12], 12'h7FF}, '0, '0);
         // Defaults again, with stray upper bits on the narrow registers
         2: write_regs({junk[11:0], 12'd2048}, {junk[23:12], 12'd0},
                       CSR_DATA_W'(GAIN_RESET), CSR_DATA_W'(GAIN_RESET));
         default:
            write_regs(CSR_DATA_W'($urandom), CSR_DATA_W'($urandom),
                       CSR_DATA_W'(pick_gain()), CSR_DATA_W'(pick_gain()));
      endcase
   endtask

   // Result side: alternate ready runs and stall gaps; one assignment per step
   initial begin
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 19) == 0) rsp_calm = ~rsp_calm;
         rsp_ready <= 1'b1;
         repeat (rsp_calm ? 200 : $urandom_range(1, 8)) @(posedge clock);
         if (pick_gap(rsp_calm) > 0) begin
            rsp_ready <= 1'b0;
            repeat (pick_gap(1'b0) + 1) @(posedge clock);
         end
      end
   end

   // Check every result transaction against the oldest owed window
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_data);
   end

   // Main sequence
   initial begin
      wrm_req_type corners [16];
      int          phase;
      int          k;

      corners[0]  = '{12'd0,    12'd0};
      corners[1]  = '{12'hFFF,  12'hFFF};
      corners[2]  = '{12'd0,    12'hFFF};
      corners[3]  = '{12'hFFF,  12'd0};
      corners[4]  = '{12'd2048, 12'd2048};
      corners[5]  = '{12'd2047, 12'd2049};
      corners[6]  = '{12'hAAA,  12'h555};
      corners[7]  = '{12'h555,  12'hAAA};
      corners[8]  = '{12'd1,    12'hFFE};
      corners[9]  = '{12'h800,  12'h7FF};
      corners[10] = '{12'h7FF,  12'h800};
      corners[11] = '{12'd2048, 12'd0};
      corners[12] = '{12'hF0F,  12'h0F0};
      corners[13] = '{12'h0F0,  12'hF0F};
      corners[14] = '{12'd2049, 12'd2047};
      corners[15] = '{12'hFFF,  12'd2048};

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Run the corners under the reset settings, then fill out a few windows
      for (k = 0; k < 16; k++) send_pair(corners[k]);
      send_random(176);

      // Random phases, each ending wherever it ends within a window
      phase = 0;
      while (sent < ITEM_TARGET || sb.windows_closed < WINDOW_TARGET) begin
         req_valid <= 1'b0;
         wait_idle();
         program_phase(phase);
         req_calm = ($urandom_range(0, 3) == 0);
         send_random($urandom_range(64, 260));
         phase++;
      end
      req_valid <= 1'b0;

      wait_idle();
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("[windowed_rms_meter_core] OK");
      end else begin
         $display("[windowed_rms_meter_core] ERROR");
      end
      $finish;
   end

   // Hard stop far beyond the slowest legal run
   initial begin
      #2000000;
      $display("[windowed_rms_meter_core] ERROR");
      $finish;
   end

endmodule
